FILE: rtl/core/wfs_pkg.sv
// ----------------------------------------------------------------------------
// wfs_pkg: shared types and constants of the waypoint follower
// Payload structs, controller state codes, command and status groups.
// ----------------------------------------------------------------------------
package wfs_pkg;

  localparam int MAX_WAYPOINTS = 16;
  localparam int SLOT_W        = $clog2(MAX_WAYPOINTS);
  localparam int TGT_W         = SLOT_W + 1;
  localparam int COORD_W       = 24;
  localparam int MAG_W         = COORD_W;          // |waypoint - position|
  localparam int SQ_W          = 2 * MAG_W + 2;    // sum of squares with headroom
  localparam int DIST_W        = MAG_W + 1;        // integer square root
  localparam int STEP_W        = 16;
  localparam int NUM_W         = MAG_W + STEP_W + 1;
  localparam int SUM_W         = 40;
  localparam int TICK_W        = 20;
  localparam int CNT_W         = 6;
  localparam int SQRT_ITER     = DIST_W;
  localparam int DIV_ITER      = NUM_W;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  // Action codes.
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_STEP   = 2'd0;
  localparam logic [1:0] REG_RADIUS = 2'd1;
  localparam logic [1:0] REG_ROUTE  = 2'd2;
  localparam logic [1:0] REG_LIMIT  = 2'd3;

  localparam logic [STEP_W-1:0] STEP_RESET   = 16'd51;
  localparam logic [STEP_W-1:0] RADIUS_RESET = 16'd128;
  localparam logic [TGT_W-1:0]  ROUTE_RESET  = '0;
  localparam logic [TICK_W-1:0] LIMIT_RESET  = 20'd100000;

  typedef struct packed {
    logic [1:0]               action;
    logic [3:0]               slot;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [4:0]                target_index;
    logic                      reached;
    logic                      route_done;
    logic                      timed_out;
    logic [SUM_W-1:0]          distance_total;
  } result_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_length;
    logic [STEP_W-1:0] arrive_radius;
    logic [4:0]        route_length;
    logic [TICK_W-1:0] tick_limit;
  } cfg_t;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DIFF  = 13'b0000000000010,
    S_SQX   = 13'b0000000000100,
    S_SQY   = 13'b0000000001000,
    S_RLD   = 13'b0000000010000,
    S_SQRT  = 13'b0000000100000,
    S_CHK   = 13'b0000001000000,
    S_NUM   = 13'b0000010000000,
    S_DIV   = 13'b0000100000000,
    S_UPD   = 13'b0001000000000,
    S_SUM   = 13'b0010000000000,
    S_REACH = 13'b0100000000000,
    S_EMIT  = 13'b1000000000000
  } state_t;

  typedef struct packed {
    logic capture;
    logic diff;
    logic sq_first;
    logic sq_acc;
    logic root_load;
    logic root_step;
    logic num_load;
    logic div_step;
    logic pos_upd;
    logic sum_add;
    logic reach;
    logic axis;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic dist_zero;
  } status_t;

endpackage

FILE: rtl/core/wfs_ctrl.sv
// ----------------------------------------------------------------------------
// wfs_ctrl: sequencer of the waypoint follower
// Steps the datapath through measure, divide, update and reach phases.
// ----------------------------------------------------------------------------
module wfs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  logic [1:0]     action,
  input  logic           result_free,
  input  wfs_pkg::status_t status,
  output wfs_pkg::cmd_t  cmd,
  output logic           item_stall,
  output logic           emit
);
  import wfs_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             axis, axis_next;
  logic             pass, pass_next;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    axis_next  = axis;
    pass_next  = pass;
    cmd        = '0;
    cmd.axis   = axis;
    emit       = 1'b0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          pass_next   = 1'b0;
          axis_next   = 1'b0;
          if (action == ACT_TICK && status.active) state_next = S_DIFF;
          else state_next = S_EMIT;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_SQX;
      end
      S_SQX: begin
        cmd.sq_first = 1'b1;
        state_next   = S_SQY;
      end
      S_SQY: begin
        cmd.sq_acc = 1'b1;
        state_next = S_RLD;
      end
      S_RLD: begin
        cmd.root_load = 1'b1;
        cnt_next      = '0;
        state_next    = S_SQRT;
      end
      S_SQRT: begin
        cmd.root_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == CNT_W'(SQRT_ITER - 1)) state_next = S_CHK;
      end
      S_CHK: begin
        if (pass || status.dist_zero) state_next = S_REACH;
        else state_next = S_NUM;
      end
      S_NUM: begin
        cmd.num_load = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_ITER - 1)) state_next = S_UPD;
      end
      S_UPD: begin
        cmd.pos_upd = 1'b1;
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = S_NUM;
        end else begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_add = 1'b1;
        pass_next   = 1'b1;
        state_next  = S_DIFF;
      end
      S_REACH: begin
        cmd.reach  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (result_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      axis  <= 1'b0;
      pass  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      axis  <= axis_next;
      pass  <= pass_next;
    end
  end

endmodule

FILE: rtl/core/wfs_dp.sv
// ----------------------------------------------------------------------------
// wfs_dp: datapath of the waypoint follower
// Waypoint table, position and progress state, shared multiplier,
// bit-serial square root and restoring divider.
// ----------------------------------------------------------------------------
module wfs_dp (
  input  logic             clk,
  input  logic             rst,
  input  wfs_pkg::cmd_t    cmd,
  input  wfs_pkg::item_t   item,
  input  wfs_pkg::cfg_t    cfg,
  output wfs_pkg::status_t status,
  output wfs_pkg::result_t view
);
  import wfs_pkg::*;

  logic signed [COORD_W-1:0] wp_x [MAX_WAYPOINTS];
  logic signed [COORD_W-1:0] wp_y [MAX_WAYPOINTS];

  logic signed [COORD_W-1:0] pos_x, pos_y;
  logic [TGT_W-1:0]          target;
  logic [SUM_W-1:0]          dist_sum;
  logic [TICK_W-1:0]         tick_cnt;
  logic                      hit;

  logic [MAG_W-1:0]  ax, ay;
  logic              sx, sy;
  logic [SQ_W-1:0]   sq;
  logic [SQ_W-1:0]   rn, root, rbit;
  logic [NUM_W-1:0]  num, quo;
  logic [DIST_W:0]   rem;

  logic [TGT_W-1:0]  len;
  logic [DIST_W-1:0] span;
  logic [STEP_W-1:0] step_eff;
  logic [MAG_W-1:0]  mul_a, mul_b;
  logic [2*MAG_W-1:0] mul_p;
  logic [SQ_W-1:0]   rtry;
  logic [DIST_W:0]   rem_sh;
  logic signed [COORD_W:0] dx, dy;
  logic signed [COORD_W-1:0] tx, ty;
  logic [MAG_W-1:0]  q;
  logic              done;

  assign len  = (cfg.route_length > 5'(MAX_WAYPOINTS)) ? TGT_W'(MAX_WAYPOINTS)
                                                       : cfg.route_length[TGT_W-1:0];
  assign span = root[DIST_W-1:0];
  assign step_eff = ({{(DIST_W-STEP_W){1'b0}}, cfg.step_length} > span)
                    ? span[STEP_W-1:0] : cfg.step_length;
  assign done = (target >= len);

  assign status.active    = !done && (tick_cnt < cfg.tick_limit);
  assign status.dist_zero = (span == '0);

  assign tx = wp_x[target[SLOT_W-1:0]];
  assign ty = wp_y[target[SLOT_W-1:0]];
  assign dx = {tx[COORD_W-1], tx} - {pos_x[COORD_W-1], pos_x};
  assign dy = {ty[COORD_W-1], ty} - {pos_y[COORD_W-1], pos_y};

  always_comb begin
    if (cmd.sq_first) begin
      mul_a = ax;
      mul_b = ax;
    end else if (cmd.sq_acc) begin
      mul_a = ay;
      mul_b = ay;
    end else begin
      mul_a = cmd.axis ? ay : ax;
      mul_b = {{(MAG_W-STEP_W){1'b0}}, step_eff};
    end
  end
  assign mul_p = mul_a * mul_b;

  assign rtry   = root + rbit;
  assign rem_sh = {rem[DIST_W-1:0], num[NUM_W-1]};
  assign q      = quo[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture && item.action == ACT_LOAD) begin
      wp_x[item.slot[SLOT_W-1:0]] <= item.coord_x;
      wp_y[item.slot[SLOT_W-1:0]] <= item.coord_y;
    end
    if (cmd.diff) begin
      sx <= dx[COORD_W];
      sy <= dy[COORD_W];
      ax <= dx[COORD_W] ? MAG_W'(-dx) : dx[MAG_W-1:0];
      ay <= dy[COORD_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];
    end
    if (cmd.sq_first) sq <= {2'b00, mul_p};
    if (cmd.sq_acc)   sq <= sq + {2'b00, mul_p};
    if (cmd.root_load) begin
      rn   <= sq;
      root <= '0;
      rbit <= SQ_W'(1) << (2 * (SQRT_ITER - 1));
    end
    if (cmd.root_step) begin
      if (rn >= rtry) begin
        rn   <= rn - rtry;
        root <= (root >> 1) + rbit;
      end else begin
        root <= root >> 1;
      end
      rbit <= rbit >> 2;
    end
    if (cmd.num_load) begin
      num <= mul_p[NUM_W-1:0] + NUM_W'(span >> 1);
      quo <= '0;
      rem <= '0;
    end
    if (cmd.div_step) begin
      num <= num << 1;
      if (rem_sh >= {1'b0, span}) begin
        rem <= rem_sh - {1'b0, span};
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x    <= '0;
      pos_y    <= '0;
      target   <= '0;
      dist_sum <= '0;
      tick_cnt <= '0;
      hit      <= 1'b0;
    end else begin
      if (cmd.capture) begin
        hit <= 1'b0;
        if (item.action == ACT_START) begin
          pos_x    <= item.coord_x;
          pos_y    <= item.coord_y;
          target   <= '0;
          dist_sum <= '0;
          tick_cnt <= '0;
        end
      end
      if (cmd.pos_upd) begin
        if (!cmd.axis) pos_x <= sx ? pos_x - q : pos_x + q;
        else pos_y <= sy ? pos_y - q : pos_y + q;
      end
      if (cmd.sum_add) begin
        if ({1'b0, dist_sum} + (SUM_W+1)'(step_eff) > {1'b0, SUM_MAX}) dist_sum <= SUM_MAX;
        else dist_sum <= dist_sum + SUM_W'(step_eff);
      end
      if (cmd.reach) begin
        if (span < DIST_W'(cfg.arrive_radius)) begin
          hit    <= 1'b1;
          target <= target + 1'b1;
        end
        if (tick_cnt != TICK_MAX) tick_cnt <= tick_cnt + 1'b1;
      end
    end
  end

  assign view.pos_x          = pos_x;
  assign view.pos_y          = pos_y;
  assign view.target_index   = 5'(target);
  assign view.reached        = hit;
  assign view.route_done     = done;
  assign view.timed_out      = !done && (tick_cnt >= cfg.tick_limit);
  assign view.distance_total = dist_sum;

endmodule

FILE: rtl/core/waypoint_follow_step.sv
// ----------------------------------------------------------------------------
// waypoint_follow_step: fixed-point waypoint follower, one tick per item
// Top level with configuration registers, controller, datapath and
// result register.
// ----------------------------------------------------------------------------
// The item channel carries load, start and tick actions; each accepted
// transfer produces exactly one result transfer that reports the vehicle
// position, target index, status flags and distance total after that item.
// Load, start, idle ticks and undefined actions go from capture straight to
// the emit state. A moving tick measures the distance with a bit-serial
// square root, divides each axis with a restoring divider and then measures
// again; a tick at zero distance only measures. These two units set the
// throughput: one item is in flight at a time.
// The result register decouples the sides: a new item is accepted while an
// earlier result still waits under result_stall, and the controller holds
// its finished result until the register frees up.
// Reset clears the position, progress, counters and configuration to their
// defaults; the waypoint table holds no defined contents until loaded.
// The user writes configuration over the APB-style port only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module waypoint_follow_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  wfs_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output wfs_pkg::result_t  result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import wfs_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  result_t view;
  logic    emit;
  logic    result_free;
  logic    cfg_wr;

  // Configuration registers; a write lands on the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_length   <= STEP_RESET;
      cfg.arrive_radius <= RADIUS_RESET;
      cfg.route_length  <= 5'(ROUTE_RESET);
      cfg.tick_limit    <= LIMIT_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_STEP:   cfg.step_length   <= pwdata[STEP_W-1:0];
        REG_RADIUS: cfg.arrive_radius <= pwdata[STEP_W-1:0];
        REG_ROUTE:  cfg.route_length  <= pwdata[4:0];
        REG_LIMIT:  cfg.tick_limit    <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_STEP:   prdata = {16'd0, cfg.step_length};
      REG_RADIUS: prdata = {16'd0, cfg.arrive_radius};
      REG_ROUTE:  prdata = {27'd0, cfg.route_length};
      REG_LIMIT:  prdata = {12'd0, cfg.tick_limit};
      default:    prdata = '0;
    endcase
  end

  // The result register can take a new result when it is empty or its
  // current transfer completes this cycle.
  assign result_free = !result_valid || !result_stall;

  wfs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .action      (item.action),
    .result_free (result_free),
    .status      (status),
    .cmd         (cmd),
    .item_stall  (item_stall),
    .emit        (emit)
  );

  wfs_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .cfg    (cfg),
    .status (status),
    .view   (view)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) result <= view;
  end

endmodule

FILE: rtl/core/wfs_checker.sv
// ----------------------------------------------------------------------------
// wfs_checker: port-level checks of the waypoint follower
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
module wfs_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input wfs_pkg::result_t result,
  input logic             result_valid,
  input logic             result_stall
);
  import wfs_pkg::*;

  // A held result stays offered until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // One item at a time: an accepted item blocks the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item accepted while busy");

  // A finished route is never reported as timed out.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.route_done && result.timed_out))
    else $error("done and timeout together");

  // A reached waypoint always advances the target past zero.
  a_reach: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.reached |-> result.target_index != 5'd0)
    else $error("reach without target advance");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind waypoint_follow_step wfs_checker u_wfs_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result       (result),
  .result_valid (result_valid),
  .result_stall (result_stall)
);

FILE: tb/sv/wfs_follow_checker.sv
// ----------------------------------------------------------------------------
// wfs_follow_checker: prediction and comparison for the waypoint follower
// Watches the item, result and configuration ports, keeps its own copy of the
// route table, vehicle state and registers, and compares every result.
// ----------------------------------------------------------------------------
module wfs_follow_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  wfs_pkg::item_t    item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  wfs_pkg::result_t  result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output int                failures,
  output int                pending,
  output int                reached_count
);
  import wfs_pkg::*;

  longint            route_x [MAX_WAYPOINTS];
  longint            route_y [MAX_WAYPOINTS];
  longint            veh_x, veh_y;
  int unsigned       target;
  logic [SUM_W-1:0]  odometer;
  logic [TICK_W-1:0] ticks;
  cfg_t              regs;
  result_t           follow_expect_q[$];

  assign pending = follow_expect_q.size();

  // Integer square root, floor, bit by bit.
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned gap_to(longint tx, longint ty);
    longint unsigned ax, ay;
    ax = (tx >= veh_x) ? tx - veh_x : veh_x - tx;
    ay = (ty >= veh_y) ? ty - veh_y : veh_y - ty;
    return floor_root(ax * ax + ay * ay);
  endfunction

  // One axis of the move, rounded to nearest with halves away from zero.
  function automatic longint axis_move(longint d, longint unsigned st,
                                       longint unsigned span);
    longint unsigned m, q;
    m = (d < 0) ? -d : d;
    q = (m * st + span / 2) / span;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic result_t advance_vehicle(item_t it);
    result_t         r;
    int unsigned     len;
    logic            hit;
    longint          tx, ty;
    longint unsigned span, st, total;
    len = (regs.route_length > MAX_WAYPOINTS) ? MAX_WAYPOINTS : regs.route_length;
    hit = 1'b0;
    case (it.action)
      ACT_LOAD: begin
        route_x[it.slot] = it.coord_x;
        route_y[it.slot] = it.coord_y;
      end
      ACT_START: begin
        veh_x    = it.coord_x;
        veh_y    = it.coord_y;
        target   = 0;
        odometer = '0;
        ticks    = '0;
      end
      ACT_TICK: begin
        if (target < len && ticks < regs.tick_limit) begin
          tx   = route_x[target];
          ty   = route_y[target];
          span = gap_to(tx, ty);
          if (span != 0) begin
            st = (regs.step_length > span) ? span : regs.step_length;
            veh_x = veh_x + axis_move(tx - veh_x, st, span);
            veh_y = veh_y + axis_move(ty - veh_y, st, span);
            total = odometer + st;
            odometer = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
          end
          // The reach test runs on the distance after the move.
          if (gap_to(tx, ty) < regs.arrive_radius) begin
            hit = 1'b1;
            target++;
          end
          if (ticks != TICK_MAX) ticks++;
        end
      end
      default: ;
    endcase
    r.pos_x          = veh_x[COORD_W-1:0];
    r.pos_y          = veh_y[COORD_W-1:0];
    r.target_index   = target[4:0];
    r.reached        = hit;
    r.route_done     = (target >= len);
    r.timed_out      = (target < len) && (ticks >= regs.tick_limit);
    r.distance_total = odometer;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      veh_x = 0;
      veh_y = 0;
      target = 0;
      odometer = '0;
      ticks = '0;
      regs.step_length   <= STEP_RESET;
      regs.arrive_radius <= RADIUS_RESET;
      regs.route_length  <= ROUTE_RESET;
      regs.tick_limit    <= LIMIT_RESET;
      failures <= 0;
      reached_count <= 0;
      follow_expect_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_STEP:   regs.step_length   <= pwdata[STEP_W-1:0];
          REG_RADIUS: regs.arrive_radius <= pwdata[STEP_W-1:0];
          REG_ROUTE:  regs.route_length  <= pwdata[4:0];
          REG_LIMIT:  regs.tick_limit    <= pwdata[TICK_W-1:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) follow_expect_q.push_back(advance_vehicle(item));
      if (result_valid && !result_stall) begin
        if (follow_expect_q.size() == 0) begin
          if (failures < 10) $display("Unexpected result transfer: %p", result);
          failures <= failures + 1;
        end else begin
          want = follow_expect_q.pop_front();
          if (result.reached) reached_count <= reached_count + 1;
          if (result.pos_x !== want.pos_x || result.pos_y !== want.pos_y ||
              result.target_index !== want.target_index ||
              result.reached !== want.reached ||
              result.route_done !== want.route_done ||
              result.timed_out !== want.timed_out ||
              result.distance_total !== want.distance_total) begin
            if (failures < 10) begin
              $display("Result mismatch at %0t", $time);
              $display("  expected %p", want);
              $display("  actual   %p", result);
            end
            failures <= failures + 1;
          end
        end
      end
    end
  end
endmodule

FILE: tb/sv/tb_waypoint_follow_step.sv
// ----------------------------------------------------------------------------
// tb_waypoint_follow_step: testbench of the waypoint follower
// Loads routes, starts the vehicle and ticks it along under several register
// settings and idling patterns; a separate checker predicts every result.
// ----------------------------------------------------------------------------
module tb_waypoint_follow_step;
  import wfs_pkg::*;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  item_t       item;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  int failures, pending, reached_count;
  int sent, received, phases;
  int gap_pct, stall_pct;

  waypoint_follow_step uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  wfs_follow_checker chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .failures(failures), .pending(pending), .reached_count(reached_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // The receiver stalls at random according to the current idling phase.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      received <= 0;
    end else begin
      result_stall <= ($urandom_range(0, 99) < stall_pct);
      if (result_valid && !result_stall) received <= received + 1;
    end
  end

  // Hand one item over; gaps are drawn before the transfer is offered, and
  // valid stays high from one item to the next when no gap is drawn.
  task automatic send_item(int act, int slot, int x, int y);
    while ($urandom_range(0, 99) < gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item.action  <= act[1:0];
    item.slot    <= slot[3:0];
    item.coord_x <= x[COORD_W-1:0];
    item.coord_y <= y[COORD_W-1:0];
    item_valid   <= 1'b1;
    do @(posedge clk); while (item_stall);
    sent++;
  endtask

  // Register write: a setup cycle, then the access cycle, then back to idle.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Every item produces one result, so idle means all results are back.
  task automatic drain_and_configure(int st, int rad, int len, int lim);
    item_valid <= 1'b0;
    @(posedge clk);
    while (received != sent) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_STEP, st);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_ROUTE, len);
    write_reg(REG_LIMIT, lim);
  endtask

  // Random traffic for one phase: mostly well-formed routes around a random
  // center with a start and a run of ticks, plus some noise items.
  task automatic route_phase(int count);
    int center_x, center_y, k, n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 99) < 12) begin
        send_item($urandom_range(0, 3), $urandom, $urandom, $urandom);
        n++;
      end else begin
        center_x = $urandom_range(0, 16000000) - 8000000;
        center_y = $urandom_range(0, 16000000) - 8000000;
        k = $urandom_range(1, 6);
        for (int s = 0; s < k; s++) begin
          send_item(ACT_LOAD, s, center_x + $urandom_range(0, 4000) - 2000,
                    center_y + $urandom_range(0, 4000) - 2000);
        end
        send_item(ACT_START, $urandom, center_x + $urandom_range(0, 1000) - 500,
                  center_y + $urandom_range(0, 1000) - 500);
        n += k + 1;
        for (int t = $urandom_range(5, 40); t > 0; t--) begin
          send_item(ACT_TICK, $urandom, $urandom, $urandom);
          n++;
        end
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    sent         = 0;
    phases       = 0;
    gap_pct      = 0;
    stall_pct    = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: fill the whole table first so no tick ever targets an
    // entry that was never loaded, with coordinate extremes in the first two.
    drain_and_configure(65535, 200, 16, 1048575);
    send_item(ACT_LOAD, 0, 8388607, 8388607);
    send_item(ACT_LOAD, 1, -8388608, -8388608);
    for (int s = 2; s < MAX_WAYPOINTS; s++) send_item(ACT_LOAD, s, s * 300, -s * 200);
    send_item(ACT_START, 0, -8388608, 8388607);
    repeat (3) send_item(ACT_TICK, 0, 0, 0);
    send_item(2'd3, 15, -1, -1);       // undefined action reports status only
    send_item(ACT_START, 0, 8388607, 8388607);
    send_item(ACT_TICK, 0, 0, 0);      // zero distance, reached at once
    send_item(ACT_TICK, 0, 0, 0);

    // Random phases under a sweep of register settings and idling patterns.
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 54; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 54; end
        default: begin gap_pct = 34; stall_pct = 34; end
      endcase
      case (p)
        0: drain_and_configure(65535, 65535, 16, 1048575);
        1: drain_and_configure(0, 0, 0, 0);
        2: drain_and_configure(300, 150, 31, 7);
        3: drain_and_configure($urandom_range(1, 65535), 0, 16, 1);
        default: drain_and_configure($urandom_range(64, 1024), $urandom_range(32, 600),
                                     $urandom_range(1, 16), $urandom_range(20, 100000));
      endcase
      route_phase(100);
      phases++;
    end

    item_valid <= 1'b0;
    @(posedge clk);
    while (received != sent) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Ran %0d items over %0d register settings; %0d waypoints reached.",
             sent, phases + 1, reached_count);
    if (failures == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", failures, pending);
      $display("Verification failed");
    end
    $finish;
  end

  // Hard limit well above the slowest legal run.
  initial begin
    #50000000;
    $display("Timeout with %0d of %0d results back", received, sent);
    $display("Verification failed");
    $finish;
  end
endmodule
